// ===== hdl/rsaq_pkg.sv =====
// Shared types, widths and command codes for the rotated sorted array query block.
`timescale 1ns / 1ps

package rsaq_pkg;

   localparam int DATA_W  = 32;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;
   localparam int ADDR_W  = 2;
   localparam int OP_W    = 4;

   // Register map (byte addresses)
   localparam logic [ADDR_W-1:0]  REG_ELEMENT_COUNT = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_RESET       = 9'd1;

   // Request kinds
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Datapath operations issued by the controller
   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_WRITE      = 4'd1;
   localparam logic [OP_W-1:0] OP_START      = 4'd2;
   localparam logic [OP_W-1:0] OP_HI_LOAD    = 4'd3;
   localparam logic [OP_W-1:0] OP_ROT_READ   = 4'd4;
   localparam logic [OP_W-1:0] OP_ROT_UPDATE = 4'd5;
   localparam logic [OP_W-1:0] OP_LB_INIT    = 4'd6;
   localparam logic [OP_W-1:0] OP_SRCH_READ  = 4'd7;
   localparam logic [OP_W-1:0] OP_LB_UPDATE  = 4'd8;
   localparam logic [OP_W-1:0] OP_UB_INIT    = 4'd9;
   localparam logic [OP_W-1:0] OP_UB_UPDATE  = 4'd10;
   localparam logic [OP_W-1:0] OP_FLOOR_READ = 4'd11;
   localparam logic [OP_W-1:0] OP_CEIL_READ  = 4'd12;
   localparam logic [OP_W-1:0] OP_PEAK_READ  = 4'd13;
   localparam logic [OP_W-1:0] OP_FINISH     = 4'd14;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic search_open;
   } stat_type;

endpackage

// ===== hdl/rsaq_if.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface rsaq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic        [rsaq_pkg::INDEX_W-1:0] entry_index;
   logic signed [rsaq_pkg::DATA_W-1:0]  entry_value;
   logic signed [rsaq_pkg::DATA_W-1:0]  search_target;

   modport source (output valid, cmd, entry_index, entry_value, search_target, input ready);
   modport sink   (input valid, cmd, entry_index, entry_value, search_target, output ready);
endinterface

interface rsaq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rsaq_pkg::DATA_W-1:0] floor_value;
   logic                               floor_found;
   logic signed [rsaq_pkg::DATA_W-1:0] ceil_value;
   logic                               ceil_found;
   logic signed [rsaq_pkg::DATA_W-1:0] minimum_value;
   logic signed [rsaq_pkg::DATA_W-1:0] peak_value;

   modport source (output valid, floor_value, floor_found, ceil_value, ceil_found,
                   minimum_value, peak_value, input ready);
   modport sink   (input valid, floor_value, floor_found, ceil_value, ceil_found,
                   minimum_value, peak_value, output ready);
endinterface

// ===== hdl/rsaq_ctrl.sv =====
// Sequencer for the three binary searches and the response handshake.
`timescale 1ns / 1ps

module rsaq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_cmd,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsaq_pkg::cmd_type  cmd,
   input  rsaq_pkg::stat_type stat
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_HI_LOAD  = 4'd1;
   localparam logic [3:0] S_ROT_CHK  = 4'd2;
   localparam logic [3:0] S_ROT_UPD  = 4'd3;
   localparam logic [3:0] S_LB_CHK   = 4'd4;
   localparam logic [3:0] S_LB_UPD   = 4'd5;
   localparam logic [3:0] S_UB_CHK   = 4'd6;
   localparam logic [3:0] S_UB_UPD   = 4'd7;
   localparam logic [3:0] S_CEIL_RD  = 4'd8;
   localparam logic [3:0] S_PEAK_RD  = 4'd9;
   localparam logic [3:0] S_FINISH   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = rsaq_pkg::OP_NONE;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == rsaq_pkg::CMD_WRITE) begin
                  cmd.op = rsaq_pkg::OP_WRITE;
               end else begin
                  cmd.op   = rsaq_pkg::OP_START;
                  state_in = S_HI_LOAD;
               end
            end
         end
         S_HI_LOAD: begin
            cmd.op   = rsaq_pkg::OP_HI_LOAD;
            state_in = S_ROT_CHK;
         end
         S_ROT_CHK: begin
            if (stat.search_open) begin
               cmd.op   = rsaq_pkg::OP_ROT_READ;
               state_in = S_ROT_UPD;
            end else begin
               cmd.op   = rsaq_pkg::OP_LB_INIT;
               state_in = S_LB_CHK;
            end
         end
         S_ROT_UPD: begin
            cmd.op   = rsaq_pkg::OP_ROT_UPDATE;
            state_in = S_ROT_CHK;
         end
         S_LB_CHK: begin
            if (stat.search_open) begin
               cmd.op   = rsaq_pkg::OP_SRCH_READ;
               state_in = S_LB_UPD;
            end else begin
               cmd.op   = rsaq_pkg::OP_UB_INIT;
               state_in = S_UB_CHK;
            end
         end
         S_LB_UPD: begin
            cmd.op   = rsaq_pkg::OP_LB_UPDATE;
            state_in = S_LB_CHK;
         end
         S_UB_CHK: begin
            if (stat.search_open) begin
               cmd.op   = rsaq_pkg::OP_SRCH_READ;
               state_in = S_UB_UPD;
            end else begin
               cmd.op   = rsaq_pkg::OP_FLOOR_READ;
               state_in = S_CEIL_RD;
            end
         end
         S_UB_UPD: begin
            cmd.op   = rsaq_pkg::OP_UB_UPDATE;
            state_in = S_UB_CHK;
         end
         S_CEIL_RD: begin
            cmd.op   = rsaq_pkg::OP_CEIL_READ;
            state_in = S_PEAK_RD;
         end
         S_PEAK_RD: begin
            cmd.op   = rsaq_pkg::OP_PEAK_READ;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = rsaq_pkg::OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/rsaq_dpath.sv =====
// Element store, search bounds, compare logic, count register and result registers.
`timescale 1ns / 1ps

module rsaq_dpath #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rsaq_pkg::cmd_type                   cmd,
   output rsaq_pkg::stat_type                  stat,
   input  logic        [rsaq_pkg::INDEX_W-1:0] entry_index,
   input  logic signed [rsaq_pkg::DATA_W-1:0]  entry_value,
   input  logic signed [rsaq_pkg::DATA_W-1:0]  search_target,
   input  logic                                cfg_write,
   input  logic        [rsaq_pkg::COUNT_W-1:0] cfg_wdata,
   output logic        [rsaq_pkg::COUNT_W-1:0] element_count,
   output logic signed [rsaq_pkg::DATA_W-1:0]  floor_value,
   output logic                                floor_found,
   output logic signed [rsaq_pkg::DATA_W-1:0]  ceil_value,
   output logic                                ceil_found,
   output logic signed [rsaq_pkg::DATA_W-1:0]  minimum_value,
   output logic signed [rsaq_pkg::DATA_W-1:0]  peak_value
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int N_W   = $clog2(MAX_ENTRIES + 1);

   logic signed [rsaq_pkg::DATA_W-1:0] element_store_ff [MAX_ENTRIES];
   logic signed [rsaq_pkg::DATA_W-1:0] rdata_ff;

   logic [rsaq_pkg::COUNT_W-1:0] count_ff;
   logic [N_W-1:0]               n_eff;

   logic [N_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, lb_ff, lb_in, mid;
   logic [IDX_W-1:0] rot_ff, rot_in;
   logic signed [rsaq_pkg::DATA_W-1:0] target_ff, target_in;
   logic signed [rsaq_pkg::DATA_W-1:0] hival_ff, hival_in, min_ff, min_in;
   logic signed [rsaq_pkg::DATA_W-1:0] flr_ff, flr_in, cel_ff, cel_in;
   logic flr_found_ff, flr_found_in, cel_found_ff, cel_found_in;

   logic signed [rsaq_pkg::DATA_W-1:0] res_floor_ff, res_ceil_ff, res_min_ff, res_peak_ff;
   logic                               res_floor_found_ff, res_ceil_found_ff;

   logic [N_W-1:0]   logical_pos;
   logic [N_W:0]     phys_sum;
   logic [IDX_W-1:0] phys_addr, raddr;
   logic             rd_en, wr_en;

   // Count as used: zero counts as one, anything above the store depth is clipped
   always_comb begin
      if (count_ff == '0) begin
         n_eff = N_W'(1);
      end else if (32'(count_ff) > MAX_ENTRIES) begin
         n_eff = N_W'(MAX_ENTRIES);
      end else begin
         n_eff = N_W'(count_ff);
      end
   end

   assign mid              = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign stat.search_open = (lo_ff < hi_ff);

   // Logical position in unrotated order -> physical store address
   always_comb begin
      case (cmd.op)
         rsaq_pkg::OP_FLOOR_READ: logical_pos = lo_ff - N_W'(1);
         rsaq_pkg::OP_CEIL_READ:  logical_pos = lb_ff;
         rsaq_pkg::OP_PEAK_READ:  logical_pos = n_eff - N_W'(1);
         default:                 logical_pos = mid;
      endcase
      phys_sum = (N_W+1)'(rot_ff) + (N_W+1)'(logical_pos);
      if (phys_sum >= (N_W+1)'(n_eff)) begin
         phys_sum = phys_sum - (N_W+1)'(n_eff);
      end
      phys_addr = phys_sum[IDX_W-1:0];
   end

   always_comb begin
      rd_en = 1'b0;
      raddr = phys_addr;
      case (cmd.op)
         rsaq_pkg::OP_START: begin
            rd_en = 1'b1;
            raddr = IDX_W'(n_eff - N_W'(1));
         end
         rsaq_pkg::OP_ROT_READ: begin
            rd_en = 1'b1;
            raddr = mid[IDX_W-1:0];
         end
         rsaq_pkg::OP_SRCH_READ, rsaq_pkg::OP_FLOOR_READ,
         rsaq_pkg::OP_CEIL_READ, rsaq_pkg::OP_PEAK_READ: begin
            rd_en = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Writes beyond the store depth are dropped
   assign wr_en = (cmd.op == rsaq_pkg::OP_WRITE) && (32'(entry_index) < MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         element_store_ff[IDX_W'(entry_index)] <= entry_value;
      end
      if (rd_en) begin
         rdata_ff <= element_store_ff[raddr];
      end
   end

   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lb_in        = lb_ff;
      rot_in       = rot_ff;
      target_in    = target_ff;
      hival_in     = hival_ff;
      min_in       = min_ff;
      flr_in       = flr_ff;
      flr_found_in = flr_found_ff;
      cel_in       = cel_ff;
      cel_found_in = cel_found_ff;
      case (cmd.op)
         rsaq_pkg::OP_START: begin
            lo_in     = '0;
            hi_in     = n_eff - N_W'(1);
            target_in = search_target;
         end
         rsaq_pkg::OP_HI_LOAD: begin
            hival_in = rdata_ff;
         end
         rsaq_pkg::OP_ROT_UPDATE: begin
            if (rdata_ff > hival_ff) begin
               lo_in = mid + N_W'(1);
            end else begin
               hi_in    = mid;
               hival_in = rdata_ff;
            end
         end
         rsaq_pkg::OP_LB_INIT: begin
            rot_in = lo_ff[IDX_W-1:0];
            min_in = hival_ff;
            lo_in  = '0;
            hi_in  = n_eff;
         end
         rsaq_pkg::OP_LB_UPDATE: begin
            if (rdata_ff < target_ff) begin
               lo_in = mid + N_W'(1);
            end else begin
               hi_in = mid;
            end
         end
         rsaq_pkg::OP_UB_INIT: begin
            lb_in = lo_ff;
            lo_in = '0;
            hi_in = n_eff;
         end
         rsaq_pkg::OP_UB_UPDATE: begin
            if (rdata_ff <= target_ff) begin
               lo_in = mid + N_W'(1);
            end else begin
               hi_in = mid;
            end
         end
         rsaq_pkg::OP_CEIL_READ: begin
            flr_found_in = (lo_ff != '0);
            flr_in       = (lo_ff != '0) ? rdata_ff : '0;
         end
         rsaq_pkg::OP_PEAK_READ: begin
            cel_found_in = (lb_ff < n_eff);
            cel_in       = (lb_ff < n_eff) ? rdata_ff : '0;
         end
         default: begin
            lo_in = lo_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      lb_ff        <= lb_in;
      rot_ff       <= rot_in;
      target_ff    <= target_in;
      hival_ff     <= hival_in;
      min_ff       <= min_in;
      flr_ff       <= flr_in;
      flr_found_ff <= flr_found_in;
      cel_ff       <= cel_in;
      cel_found_ff <= cel_found_in;
      if (cmd.op == rsaq_pkg::OP_FINISH) begin
         res_floor_ff       <= flr_ff;
         res_floor_found_ff <= flr_found_ff;
         res_ceil_ff        <= cel_ff;
         res_ceil_found_ff  <= cel_found_ff;
         res_min_ff         <= min_ff;
         res_peak_ff        <= rdata_ff;
      end
   end

   assign floor_value   = res_floor_ff;
   assign floor_found   = res_floor_found_ff;
   assign ceil_value    = res_ceil_ff;
   assign ceil_found    = res_ceil_found_ff;
   assign minimum_value = res_min_ff;
   assign peak_value    = res_peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= rsaq_pkg::COUNT_RESET;
      end else if (cfg_write) begin
         count_ff <= cfg_wdata;
      end
   end

   assign element_count = count_ff;

endmodule

// ===== hdl/rotated_sorted_array_query.sv =====
// Top level of the rotated sorted array query block.
`timescale 1ns / 1ps

// Holds up to MAX_ENTRIES signed 32-bit words, meant to form a rotated ascending
// run of distinct values, and answers queries against the first element_count
// entries. A request with cmd = 0 stores entry_value at entry_index and gives
// no response; an index at or beyond MAX_ENTRIES is dropped.
// A request with cmd = 1 runs three binary searches over the single-port
// element store: one for the rotation point (minimum, with the entry before it
// as the peak), then lower and upper bound searches in unrotated order that
// give the ceil and floor of search_target with found flags; a missing floor
// or ceil reads as zero. Every search step is a registered memory read followed
// by a compare. The next request is taken while a response still waits in the
// output register. Entries must be written before a query reads them.
// element_count sits at byte address 0 of the register port; zero acts as one
// and values above MAX_ENTRIES clip.
module rotated_sorted_array_query #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   rsaq_req_if.sink                            req_ch,
   rsaq_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic        [rsaq_pkg::ADDR_W-1:0]  paddr,
   input  logic        [31:0]                  pwdata,
   output logic        [31:0]                  prdata,
   output logic                                pready
);

   rsaq_pkg::cmd_type            cmd;
   rsaq_pkg::stat_type           stat;
   logic                         cfg_write;
   logic [rsaq_pkg::COUNT_W-1:0] element_count;

   // Register writes land in the access phase; the port never waits
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr == rsaq_pkg::REG_ELEMENT_COUNT);
   assign prdata    = (paddr == rsaq_pkg::REG_ELEMENT_COUNT) ? 32'(element_count) : '0;

   // Controller: accepts requests, steps the searches, owns response valid
   rsaq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath: element store, search bounds, count register, response payload
   rsaq_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .entry_index   (req_ch.entry_index),
      .entry_value   (req_ch.entry_value),
      .search_target (req_ch.search_target),
      .cfg_write     (cfg_write),
      .cfg_wdata     (pwdata[rsaq_pkg::COUNT_W-1:0]),
      .element_count (element_count),
      .floor_value   (rsp_ch.floor_value),
      .floor_found   (rsp_ch.floor_found),
      .ceil_value    (rsp_ch.ceil_value),
      .ceil_found    (rsp_ch.ceil_found),
      .minimum_value (rsp_ch.minimum_value),
      .peak_value    (rsp_ch.peak_value)
   );

endmodule

// ===== hdl/rsaq_checker.sv =====
// Port-level assertions for the rotated sorted array query block, with its bind.
`timescale 1ns / 1ps

module rsaq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_cmd,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [rsaq_pkg::DATA_W-1:0] floor_value,
   input logic                               floor_found,
   input logic signed [rsaq_pkg::DATA_W-1:0] ceil_value,
   input logic                               ceil_found,
   input logic signed [rsaq_pkg::DATA_W-1:0] minimum_value,
   input logic signed [rsaq_pkg::DATA_W-1:0] peak_value
);

   // A stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(floor_value) && $stable(ceil_value)
         && $stable(minimum_value) && $stable(peak_value))
      else $error("stalled response changed");

   // An accepted query blocks further requests while it searches
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == rsaq_pkg::CMD_QUERY) |=> !req_ready)
      else $error("request taken during a query");

   // A write request never creates a response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == rsaq_pkg::CMD_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("response after a write request");

   // A missing floor or ceil reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (floor_found || floor_value == '0) && (ceil_found || ceil_value == '0))
      else $error("missing bound not zero");

endmodule

bind rotated_sorted_array_query rsaq_checker u_rsaq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_cmd       (req_ch.cmd),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .floor_value   (rsp_ch.floor_value),
   .floor_found   (rsp_ch.floor_found),
   .ceil_value    (rsp_ch.ceil_value),
   .ceil_found    (rsp_ch.ceil_found),
   .minimum_value (rsp_ch.minimum_value),
   .peak_value    (rsp_ch.peak_value)
);

// ===== tb/sv/tb_rotated_sorted_array_query.sv =====
// Self-checking testbench for the rotated sorted array query block.
`timescale 1ns / 1ps

module tb_rotated_sorted_array_query;

   localparam int STORE_DEPTH  = 256;
   // Longer than the slowest query; the block is given this much idle time before a register write.
   localparam int IDLE_SETTLE  = 80;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int INT_LOW      = 32'h8000_0000;
   localparam int INT_HIGH     = 32'h7fff_ffff;

   // How a phase fills the active entries
   typedef enum int {
      FILL_SPREAD,     // distinct values over the whole signed range, rotated
      FILL_DENSE,      // distinct values packed close together, rotated
      FILL_EXTREME,    // values hugging both ends of the signed range, rotated
      FILL_SCRAMBLED,  // random values in no order
      FILL_CLUSTER     // small values with repeats, in no order
   } fill_mode_type;

   typedef struct packed {
      logic signed [rsaq_pkg::DATA_W-1:0] floor_value;
      logic                               floor_found;
      logic signed [rsaq_pkg::DATA_W-1:0] ceil_value;
      logic                               ceil_found;
      logic signed [rsaq_pkg::DATA_W-1:0] minimum_value;
      logic signed [rsaq_pkg::DATA_W-1:0] peak_value;
   } query_result_type;

   // Mirror of the element store and the count register, plus the answers still owed.
   class query_scoreboard_type;
      logic signed [rsaq_pkg::DATA_W-1:0] element_model [STORE_DEPTH];
      logic [rsaq_pkg::COUNT_W-1:0]       count_reg;
      query_result_type                   expected_results [$];
      int unsigned                        mismatches;
      int unsigned                        checked;

      function new();
         count_reg  = rsaq_pkg::COUNT_RESET;
         mismatches = 0;
         checked    = 0;
         foreach (element_model[i]) element_model[i] = '0;
      endfunction

      function void set_count(logic [31:0] wdata);
         count_reg = wdata[rsaq_pkg::COUNT_W-1:0];
      endfunction

      // Zero acts as one, anything past the store depth clips.
      function int unsigned active_count();
         int unsigned n;
         n = 32'(count_reg);
         if (n == 0) n = 1;
         if (n > STORE_DEPTH) n = STORE_DEPTH;
         return n;
      endfunction

      // Physical slot of position i in the unrotated order.
      function int unsigned unrotate(int unsigned rot, int unsigned i, int unsigned n);
         int unsigned p;
         p = rot + i;
         return (p >= n) ? p - n : p;
      endfunction

      function query_result_type predict_query(logic signed [rsaq_pkg::DATA_W-1:0] target);
         int unsigned      n, lo, hi, mid, rot, lb, ub;
         query_result_type r;
         n = active_count();
         // rotation point: the minimum
         lo = 0;
         hi = n - 1;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (element_model[mid] > element_model[hi]) lo = mid + 1;
            else hi = mid;
         end
         rot = lo;
         // first unrotated position not below the target
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (element_model[unrotate(rot, mid, n)] < target) lo = mid + 1;
            else hi = mid;
         end
         lb = lo;
         // first unrotated position above the target
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (element_model[unrotate(rot, mid, n)] <= target) lo = mid + 1;
            else hi = mid;
         end
         ub = lo;
         r.floor_found   = (ub > 0);
         r.floor_value   = (ub > 0) ? element_model[unrotate(rot, ub - 1, n)] : '0;
         r.ceil_found    = (lb < n);
         r.ceil_value    = (lb < n) ? element_model[unrotate(rot, lb, n)] : '0;
         r.minimum_value = element_model[rot];
         r.peak_value    = element_model[unrotate(rot, n - 1, n)];
         return r;
      endfunction

      function void note_request(logic cmd, logic [rsaq_pkg::INDEX_W-1:0] idx,
                                 logic signed [rsaq_pkg::DATA_W-1:0] value,
                                 logic signed [rsaq_pkg::DATA_W-1:0] target);
         if (cmd == rsaq_pkg::CMD_WRITE) element_model[idx] = value;
         else expected_results.push_back(predict_query(target));
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void compare_field(string field, logic [rsaq_pkg::DATA_W-1:0] want,
                                  logic [rsaq_pkg::DATA_W-1:0] got);
         if (got !== want)
            flag($sformatf("response %0d: %s expected %h, got %h", checked, field, want, got));
      endfunction

      function void check_response(query_result_type got);
         query_result_type want;
         checked++;
         if (expected_results.size() == 0) begin
            flag($sformatf("response %0d arrived with no query waiting", checked));
            return;
         end
         want = expected_results.pop_front();
         compare_field("floor_value", want.floor_value, got.floor_value);
         compare_field("floor_found", 32'(want.floor_found), 32'(got.floor_found));
         compare_field("ceil_value", want.ceil_value, got.ceil_value);
         compare_field("ceil_found", 32'(want.ceil_found), 32'(got.ceil_found));
         compare_field("minimum_value", want.minimum_value, got.minimum_value);
         compare_field("peak_value", want.peak_value, got.peak_value);
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [rsaq_pkg::ADDR_W-1:0] paddr;
   logic [31:0]                 pwdata;
   logic [31:0]                 prdata;
   logic                        pready;

   rsaq_req_if req_ch ();
   rsaq_rsp_if rsp_ch ();

   query_scoreboard_type sb;
   int unsigned          items_sent;
   int unsigned          burst_left;
   int unsigned          cycle_count;
   int unsigned          hold_left;
   int unsigned          calm_left;
   int unsigned          next_pressure_at;

   rotated_sorted_array_query u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side: check every accepted response, then pick ready for the next cycle.
   // Mostly ready, with short and occasional long hold-offs, calm stretches with no
   // hold-off at all, and a few very long hold-offs so the block backs up into its input.
   always @(posedge clock) begin : rsp_side
      query_result_type got;
      int unsigned      roll;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.floor_value   = rsp_ch.floor_value;
         got.floor_found   = rsp_ch.floor_found;
         got.ceil_value    = rsp_ch.ceil_value;
         got.ceil_found    = rsp_ch.ceil_found;
         got.minimum_value = rsp_ch.minimum_value;
         got.peak_value    = rsp_ch.peak_value;
         sb.check_response(got);
      end
      if (!reset && sb.checked >= next_pressure_at) begin
         hold_left        = 400;
         next_pressure_at = next_pressure_at + 500;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            roll = $urandom_range(0, 999);
            if (roll < 5) calm_left = $urandom_range(150, 300);
            else if (roll < 150) hold_left = $urandom_range(1, 3);
            else if (roll < 170) hold_left = $urandom_range(10, 80);
         end
      end
   end

   // Offer one request after a random gap, hold it until accepted, then log it.
   task automatic send_request(logic cmd, logic [rsaq_pkg::INDEX_W-1:0] idx,
                               logic signed [rsaq_pkg::DATA_W-1:0] value,
                               logic signed [rsaq_pkg::DATA_W-1:0] target);
      int unsigned gap, roll;
      roll = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (roll < 3) begin
         burst_left = $urandom_range(20, 60);
         gap        = 0;
      end else if (roll < 60) begin
         gap = 0;
      end else if (roll < 95) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 60);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= cmd;
      req_ch.entry_index   <= idx;
      req_ch.entry_value   <= value;
      req_ch.search_target <= target;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(cmd, idx, value, target);
      items_sent++;
   endtask

   // Drop valid, wait for every owed response, then let any write finish inside the block.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; junk in the upper data bits must be dropped.
   task automatic write_count(int unsigned value);
      logic [31:0] wdata;
      wdata   = ($urandom & ~32'h1ff) | (value & 32'h1ff);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= rsaq_pkg::REG_ELEMENT_COUNT;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.set_count(wdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // One phase: set the count while idle, load every active entry, then run queries
   // with a sprinkle of stray writes, some of which break the sorted order.
   task automatic run_phase(int unsigned count_value, fill_mode_type mode);
      int          sorted [STORE_DEPTH];
      int          pattern [STORE_DEPTH];
      int          j, k, tmp, tgt;
      int unsigned n, rot, nq, roll, sel, slot;
      bit          dup;
      settle();
      write_count(count_value);
      n = sb.active_count();
      case (mode)
         FILL_SPREAD: begin
            // redraw until all values differ
            do begin
               for (j = 0; j < n; j++) sorted[j] = $urandom;
               for (j = 1; j < n; j++) begin
                  tmp = sorted[j];
                  k   = j;
                  while (k > 0 && sorted[k-1] > tmp) begin
                     sorted[k] = sorted[k-1];
                     k--;
                  end
                  sorted[k] = tmp;
               end
               dup = 1'b0;
               for (j = 1; j < n; j++) if (sorted[j] == sorted[j-1]) dup = 1'b1;
            end while (dup);
         end
         FILL_DENSE: begin
            sorted[0] = int'($urandom_range(0, 2000)) - 1000;
            for (j = 1; j < n; j++) sorted[j] = sorted[j-1] + int'($urandom_range(1, 4));
         end
         FILL_EXTREME: begin
            for (j = 0; j < n; j++) begin
               if (j < n / 2) sorted[j] = INT_LOW + j;
               else sorted[j] = INT_HIGH - (int'(n) - 1 - j);
            end
         end
         FILL_SCRAMBLED: begin
            for (j = 0; j < n; j++) sorted[j] = $urandom;
         end
         default: begin
            for (j = 0; j < n; j++) sorted[j] = int'($urandom_range(0, 15)) - 8;
         end
      endcase
      // favor the unrotated case now and then
      rot = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, n - 1);
      for (j = 0; j < n; j++) begin
         pattern[j] = sorted[(j + n - rot) % n];
         send_request(rsaq_pkg::CMD_WRITE, rsaq_pkg::INDEX_W'(j), pattern[j], $urandom);
      end
      nq = $urandom_range(8, 30);
      for (j = 0; j < nq; j++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            slot = $urandom_range(0, STORE_DEPTH - 1);
            tmp  = $urandom;
            send_request(rsaq_pkg::CMD_WRITE, rsaq_pkg::INDEX_W'(slot), tmp, $urandom);
            if (slot < n) pattern[slot] = tmp;
         end else begin
            sel  = $urandom_range(0, 9);
            slot = $urandom_range(0, n - 1);
            case (sel)
               0, 1, 2, 3: tgt = pattern[slot];
               4:          tgt = pattern[slot] + 1;
               5:          tgt = pattern[slot] - 1;
               6:          tgt = INT_LOW;
               7:          tgt = INT_HIGH;
               default:    tgt = $urandom;
            endcase
            send_request(rsaq_pkg::CMD_QUERY, rsaq_pkg::INDEX_W'($urandom), $urandom, tgt);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned   roll, count_value;
      fill_mode_type mode;
      sb               = new();
      items_sent       = 0;
      burst_left       = 0;
      cycle_count      = 0;
      hold_left        = 0;
      calm_left        = 0;
      next_pressure_at = 100;
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = rsaq_pkg::CMD_WRITE;
      req_ch.entry_index   = '0;
      req_ch.entry_value   = '0;
      req_ch.search_target = '0;
      rsp_ch.ready         = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one active entry from reset, at both ends of the range and at zero.
      send_request(rsaq_pkg::CMD_WRITE, 0, INT_LOW, 0);
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, INT_LOW);     // target hits the entry
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, INT_HIGH);    // no ceil
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, 0);
      send_request(rsaq_pkg::CMD_WRITE, 0, INT_HIGH, INT_LOW);
      send_request(rsaq_pkg::CMD_QUERY, 8'hff, INT_LOW, INT_LOW);   // no floor
      send_request(rsaq_pkg::CMD_QUERY, 8'hff, INT_HIGH, INT_HIGH);
      send_request(rsaq_pkg::CMD_WRITE, 8'hff, 32'h5a5a_a5a5, INT_HIGH);  // top index, unused slot
      send_request(rsaq_pkg::CMD_WRITE, 0, 0, INT_HIGH);
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, -1);
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, 1);
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, 0);
      // A count of zero acts as one.
      settle();
      write_count(0);
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, 7);
      send_request(rsaq_pkg::CMD_QUERY, 0, 0, -7);

      // Smallest real array, then the full store.
      run_phase(2, FILL_EXTREME);
      run_phase(STORE_DEPTH, FILL_SPREAD);

      // Random phases: mostly small arrays, a few large, some counts out of range.
      while (items_sent < 900) begin
         roll = $urandom_range(0, 19);
         if (roll < 13) count_value = $urandom_range(1, 16);
         else if (roll < 17) count_value = $urandom_range(17, 64);
         else if (roll < 18) count_value = 0;
         else if (roll < 19) count_value = $urandom_range(65, 255);
         else count_value = $urandom_range(257, 511);
         roll = $urandom_range(0, 19);
         if (roll < 7) mode = FILL_SPREAD;
         else if (roll < 13) mode = FILL_DENSE;
         else if (roll < 17) mode = FILL_EXTREME;
         else if (roll < 19) mode = FILL_SCRAMBLED;
         else mode = FILL_CLUSTER;
         run_phase(count_value, mode);
      end

      // All count bits set clips to the full store; finish back at one entry.
      run_phase(511, FILL_DENSE);
      run_phase(1, FILL_SPREAD);

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rsaq_pkg.sv
hdl/rsaq_if.sv
hdl/rsaq_ctrl.sv
hdl/rsaq_dpath.sv
hdl/rotated_sorted_array_query.sv
hdl/rsaq_checker.sv
tb/sv/tb_rotated_sorted_array_query.sv
